[hdl/iphc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IPv4 receive header check: shared types and constants
// Verdict codes, header word positions, register decode and the header
// view that the accumulator hands to the verdict logic.
// ---------------------------------------------------------------------------
package iphc_pkg;

	localparam int POS_W = 5;

	typedef enum logic [2:0] {
		VERDICT_MORE          = 3'd0,
		VERDICT_COMPLETE      = 3'd1,
		VERDICT_NOT_ADDRESSED = 3'd2,
		VERDICT_CHECKSUM      = 3'd3,
		VERDICT_TIMEOUT       = 3'd4,
		VERDICT_LOST          = 3'd5
	} verdict_t;

	// Word positions of the captured header fields.
	localparam logic [POS_W-1:0] POS_LENGTH    = 5'd1;
	localparam logic [POS_W-1:0] POS_IDENT     = 5'd2;
	localparam logic [POS_W-1:0] POS_FLAGS     = 5'd3;
	localparam logic [POS_W-1:0] POS_PROTOCOL  = 5'd4;
	localparam logic [POS_W-1:0] POS_DEST_HIGH = 5'd8;
	localparam logic [POS_W-1:0] POS_DEST_LOW  = 5'd9;

	localparam logic [15:0] MORE_FRAGMENTS = 16'h2000;
	localparam logic [31:0] BROADCAST_ADDR = 32'hFFFF_FFFF;
	localparam logic [15:0] SUM_ZERO       = 16'h0000;
	localparam logic [15:0] SUM_ONES       = 16'hFFFF;

	// Register select is address bit 2: local address at 0, timeout at 4.
	localparam logic REG_LOCAL_ADDRESS = 1'b0;
	localparam logic REG_GAP_TIMEOUT   = 1'b1;
	localparam logic [7:0] GAP_TIMEOUT_RESET = 8'd30;

	typedef struct packed {
		logic        last;
		logic [15:0] sum;
		logic [15:0] length;
		logic [15:0] ident;
		logic [15:0] flags;
		logic [7:0]  protocol;
		logic [31:0] dest;
	} hdr_view_t;

endpackage

[hdl/iphc_hdr_accum.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IPv4 header accumulator
// Counts header words, keeps the ones' complement sum and captures the
// header fields. The view it drives already includes the current word.
// ---------------------------------------------------------------------------
module iphc_hdr_accum #(
	parameter int HEADER_WORDS = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [15:0]         word,
	output iphc_pkg::hdr_view_t view
);
	import iphc_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(HEADER_WORDS - 1);

	logic [POS_W-1:0] pos_q;
	logic [15:0]      sum_q;
	logic [15:0]      length_q;
	logic [15:0]      ident_q;
	logic [15:0]      flags_q;
	logic [7:0]       protocol_q;
	logic [31:0]      dest_q;
	logic [16:0]      raw_sum;

	always_comb begin
		raw_sum       = {1'b0, sum_q} + {1'b0, word};
		// End-around carry: the low half is at most 0xFFFE when a carry comes out.
		view.sum      = raw_sum[15:0] + {15'b0, raw_sum[16]};
		view.last     = (pos_q == LAST_POS);
		view.length   = (pos_q == POS_LENGTH) ? word : length_q;
		view.ident    = (pos_q == POS_IDENT) ? word : ident_q;
		view.flags    = (pos_q == POS_FLAGS) ? word : flags_q;
		view.protocol = (pos_q == POS_PROTOCOL) ? word[7:0] : protocol_q;
		view.dest     = dest_q;
		if (pos_q == POS_DEST_HIGH) begin
			view.dest[31:16] = word;
		end
		if (pos_q == POS_DEST_LOW) begin
			view.dest[15:0] = word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			sum_q      <= '0;
			length_q   <= '0;
			ident_q    <= '0;
			flags_q    <= '0;
			protocol_q <= '0;
			dest_q     <= '0;
		end else if (step) begin
			if (view.last) begin
				pos_q <= '0;
				sum_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
				sum_q <= view.sum;
			end
			length_q   <= view.length;
			ident_q    <= view.ident;
			flags_q    <= view.flags;
			protocol_q <= view.protocol;
			dest_q     <= view.dest;
		end
	end

endmodule

[hdl/ipv4_receive_header_check.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IPv4 receive header check
// Checks a fixed-length IPv4 header for address and checksum, watches the
// gap between accepted packets and tracks in-order fragments.
// ---------------------------------------------------------------------------
// One header word is taken per clock with no gaps between headers, except
// while the input stalls. Each word goes into the input register; from there
// it is added into the checksum and captured, and after the last word of a
// header the verdict is written to the result register, from which the
// verdict item is offered. The input stalls only while a verdict is waiting in
// the result register and the word in the input register is another last
// word. Configuration is written through the APB port: local address at
// byte address 0, gap timeout in seconds at byte address 4 (reset 30).
module ipv4_receive_header_check #(
	parameter int HEADER_WORDS = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // header_word[15:0], arrival_seconds[47:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // verdict[2:0], payload_length[18:3],
	                               // write_offset[34:19], datagram_length[50:35],
	                               // upper_protocol[58:51], zeros[63:59]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import iphc_pkg::*;

	localparam logic [15:0] HDR_BYTES = 16'(2 * HEADER_WORDS);

	logic        valid_s1;
	logic [15:0] word_s1;
	logic [31:0] time_s1;

	logic        valid_s2;
	verdict_t    verdict_s2;
	logic [15:0] payload_s2;
	logic [15:0] woff_s2;
	logic [15:0] dlen_s2;
	logic [7:0]  proto_s2;

	logic [31:0] local_address_q;
	logic [7:0]  gap_timeout_q;
	logic [15:0] expected_ident_q;
	logic [15:0] fill_offset_q;
	logic [31:0] last_arrival_q;
	logic        arrival_seen_q;

	hdr_view_t   view;
	logic        step;
	logic        cfg_write;

	verdict_t    verdict_d;
	logic [15:0] payload_d;
	logic [15:0] woff_d;
	logic [15:0] dlen_d;
	logic [15:0] fill_sum;
	logic [15:0] fill_next;
	logic [15:0] ident_next;
	logic [31:0] gap;
	logic        addr_ok;
	logic        sum_ok;
	logic        timed_out;
	logic        passed;

	// A word that ends a header may move only when the result slot is free.
	assign step     = valid_s1 && (!view.last || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || step;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, proto_s2, dlen_s2, woff_s2, payload_s2, verdict_s2};

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_GAP_TIMEOUT) ? {24'b0, gap_timeout_q}
	                                                : local_address_q;

	iphc_hdr_accum #(
		.HEADER_WORDS(HEADER_WORDS)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.word   (word_s1),
		.view   (view)
	);

	always_comb begin
		payload_d  = (view.length > HDR_BYTES) ? view.length - HDR_BYTES : '0;
		addr_ok    = (view.dest == local_address_q) || (view.dest == BROADCAST_ADDR);
		sum_ok     = (view.sum == SUM_ZERO) || (view.sum == SUM_ONES);
		gap        = arrival_seen_q ? time_s1 - last_arrival_q : '0;
		timed_out  = gap >= {24'b0, gap_timeout_q};
		fill_sum   = fill_offset_q + payload_d;
		passed     = 1'b0;
		verdict_d  = VERDICT_NOT_ADDRESSED;
		woff_d     = '0;
		dlen_d     = '0;
		fill_next  = fill_offset_q;
		ident_next = expected_ident_q;
		if (!addr_ok) begin
			verdict_d = VERDICT_NOT_ADDRESSED;
		end else if (!sum_ok) begin
			verdict_d = VERDICT_CHECKSUM;
		end else begin
			passed = 1'b1;
			if (timed_out) begin
				verdict_d = VERDICT_TIMEOUT;
			end else if (view.ident == expected_ident_q) begin
				woff_d = fill_offset_q;
				if ((view.flags & MORE_FRAGMENTS) != '0) begin
					verdict_d = VERDICT_MORE;
					fill_next = fill_sum;
				end else begin
					verdict_d  = VERDICT_COMPLETE;
					dlen_d     = fill_sum;
					fill_next  = '0;
					ident_next = expected_ident_q + 1'b1;
				end
			end else begin
				verdict_d  = VERDICT_LOST;
				fill_next  = '0;
				ident_next = expected_ident_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			local_address_q  <= '0;
			gap_timeout_q    <= GAP_TIMEOUT_RESET;
			expected_ident_q <= '0;
			fill_offset_q    <= '0;
			last_arrival_q   <= '0;
			arrival_seen_q   <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end

			if (step && view.last) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end

			if (step && view.last) begin
				fill_offset_q    <= fill_next;
				expected_ident_q <= ident_next;
				if (passed) begin
					last_arrival_q <= time_s1;
					arrival_seen_q <= 1'b1;
				end
			end

			if (cfg_write) begin
				if (paddr[2] == REG_GAP_TIMEOUT) begin
					gap_timeout_q <= pwdata[7:0];
				end else begin
					local_address_q <= pwdata;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_s1 <= s_tdata[15:0];
			time_s1 <= s_tdata[47:16];
		end
		if (step && view.last) begin
			verdict_s2 <= verdict_d;
			payload_s2 <= payload_d;
			woff_s2    <= woff_d;
			dlen_s2    <= dlen_d;
			proto_s2   <= view.protocol;
		end
	end

	a_result_from_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1 && view.last))
		else $error("result appeared without a last header word");

	a_reject_clears_offsets: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && verdict_s2 != VERDICT_MORE && verdict_s2 != VERDICT_COMPLETE)
		|-> (woff_s2 == '0 && dlen_s2 == '0))
		else $error("rejected item carries an offset or length");

	a_more_has_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && verdict_s2 == VERDICT_MORE) |-> dlen_s2 == '0)
		else $error("fragment item carries a datagram length");

	a_complete_resets_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(step && view.last && verdict_d == VERDICT_COMPLETE)
		|=> (fill_offset_q == '0 && expected_ident_q == $past(expected_ident_q) + 1'b1))
		else $error("completion did not restart the fill offset");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> verdict_s2 <= VERDICT_LOST)
		else $error("verdict code out of range");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IPv4 receive header check testbench
// Streams whole headers into the block, predicts each verdict with an
// independent model of the checks and compares every verdict item field by
// field. Phases change the local address and the gap timeout while the block
// is idle, and vary idling and back-pressure on both streams.
// ---------------------------------------------------------------------------
module testbench;
	import iphc_pkg::*;

	localparam int HDR_WORDS = 30;
	localparam logic [15:0] HDR_BYTES = 16'(2 * HDR_WORDS);
	localparam int CSUM_POS = 5;
	localparam int SETTLE_CYCLES = 8;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;

	typedef logic [15:0] hdr_words_t [HDR_WORDS];

	typedef struct {
		verdict_t    verdict;
		logic [15:0] payload_len;
		logic [15:0] wr_offset;
		logic [15:0] dgram_len;
		logic [7:0]  protocol;
	} verdict_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // header_word[15:0], arrival_seconds[47:16]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // verdict[2:0], payload_length[18:3],
	                             // write_offset[34:19], datagram_length[50:35],
	                             // upper_protocol[58:51], zeros[63:59]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	ipv4_receive_header_check #(
		.HEADER_WORDS(HDR_WORDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [47:0]  word_q[$];
	verdict_rec_t verdict_q[$];
	int items_queued = 0;
	int items_accepted = 0;
	int error_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_requests = 0;
	int rx_hold_served = 0;
	int rx_hold_left = 0;
	int unsigned cycle_count = 0;

	// Predicted configuration and header-check state.
	logic [31:0]      cfg_local_addr = '0;
	logic [7:0]       cfg_gap_limit = GAP_TIMEOUT_RESET;
	logic [POS_W-1:0] hdr_pos = '0;
	logic [15:0]      run_sum = '0;
	logic [15:0]      len_cap = '0;
	logic [15:0]      ident_cap = '0;
	logic [15:0]      flags_cap = '0;
	logic [7:0]       proto_cap = '0;
	logic [31:0]      dest_cap = '0;
	logic [15:0]      ident_next = '0;
	logic [15:0]      buf_fill = '0;
	logic [31:0]      prev_arrival = '0;
	logic             arrival_valid = 1'b0;

	// Stimulus-side guess of the datagram number and last accepted time.
	logic [15:0] gen_ident = '0;
	logic [31:0] gen_prev = '0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		$display("tb: mismatch at %0t ns: %s", $realtime, msg);
	endtask

	task automatic predict_word(logic [47:0] item);
		logic [15:0] w;
		logic [31:0] now;
		logic [31:0] gap;
		logic [15:0] payload;
		verdict_rec_t r;
		w = item[15:0];
		now = item[47:16];
		run_sum = ones_add(run_sum, w);
		case (hdr_pos)
			POS_LENGTH:    len_cap = w;
			POS_IDENT:     ident_cap = w;
			POS_FLAGS:     flags_cap = w;
			POS_PROTOCOL:  proto_cap = w[7:0];
			POS_DEST_HIGH: dest_cap[31:16] = w;
			POS_DEST_LOW:  dest_cap[15:0] = w;
			default:       ;
		endcase
		if (int'(hdr_pos) + 1 < HDR_WORDS) begin
			hdr_pos++;
			return;
		end
		hdr_pos = '0;
		payload = (len_cap > HDR_BYTES) ? len_cap - HDR_BYTES : 16'd0;
		r.payload_len = payload;
		r.wr_offset = '0;
		r.dgram_len = '0;
		r.protocol = proto_cap;
		if (dest_cap != cfg_local_addr && dest_cap != BROADCAST_ADDR)
			r.verdict = VERDICT_NOT_ADDRESSED;
		else if (run_sum != SUM_ZERO && run_sum != SUM_ONES)
			r.verdict = VERDICT_CHECKSUM;
		else begin
			// The first accepted packet counts as having no gap at all.
			gap = arrival_valid ? now - prev_arrival : 32'd0;
			arrival_valid = 1'b1;
			prev_arrival = now;
			if (gap >= {24'd0, cfg_gap_limit})
				r.verdict = VERDICT_TIMEOUT;
			else if (ident_cap == ident_next) begin
				r.wr_offset = buf_fill;
				buf_fill = buf_fill + payload;
				if ((flags_cap & MORE_FRAGMENTS) != 16'd0)
					r.verdict = VERDICT_MORE;
				else begin
					r.verdict = VERDICT_COMPLETE;
					r.dgram_len = buf_fill;
					buf_fill = '0;
					ident_next++;
				end
			end else begin
				r.verdict = VERDICT_LOST;
				buf_fill = '0;
				ident_next++;
			end
		end
		run_sum = '0;
		verdict_q.push_back(r);
	endtask

	task automatic check_verdict(logic [63:0] d);
		verdict_rec_t e;
		if (verdict_q.size() == 0) begin
			report_mismatch($sformatf("verdict item %h with none pending", d));
			return;
		end
		e = verdict_q.pop_front();
		if (d[2:0] != e.verdict)
			report_mismatch($sformatf("verdict %0d, want %s", d[2:0], e.verdict.name()));
		if (d[18:3] != e.payload_len)
			report_mismatch($sformatf("payload_length %h, want %h", d[18:3], e.payload_len));
		if (d[34:19] != e.wr_offset)
			report_mismatch($sformatf("write_offset %h, want %h", d[34:19], e.wr_offset));
		if (d[50:35] != e.dgram_len)
			report_mismatch($sformatf("datagram_length %h, want %h", d[50:35], e.dgram_len));
		if (d[58:51] != e.protocol)
			report_mismatch($sformatf("upper_protocol %h, want %h", d[58:51], e.protocol));
	endtask

	// Only the last word of a header carries the arrival time that counts.
	task automatic push_header(hdr_words_t w, logic [31:0] now);
		for (int i = 0; i < HDR_WORDS; i++)
			word_q.push_back({(i == HDR_WORDS - 1) ? now : 32'($urandom), w[i]});
		items_queued += HDR_WORDS;
	endtask

	task automatic send_packet(logic [31:0] dest, logic [15:0] len, logic [15:0] ident,
			logic [15:0] flags, logic [7:0] proto, bit sum_ok, logic [31:0] now);
		hdr_words_t w;
		logic [15:0] acc;
		foreach (w[i]) w[i] = 16'($urandom);
		w[POS_LENGTH] = len;
		w[POS_IDENT] = ident;
		w[POS_FLAGS] = flags;
		w[POS_PROTOCOL][7:0] = proto;
		w[POS_DEST_HIGH] = dest[31:16];
		w[POS_DEST_LOW] = dest[15:0];
		w[CSUM_POS] = '0;
		acc = '0;
		foreach (w[i]) acc = ones_add(acc, w[i]);
		w[CSUM_POS] = ~acc;
		// Flipping one bit moves the folded total off both accepted values.
		if (!sum_ok)
			w[CSUM_POS] ^= 16'h1 << $urandom_range(15, 0);
		push_header(w, now);
	endtask

	task automatic random_packet();
		int kind;
		logic [31:0] dest;
		logic [31:0] gap;
		logic [31:0] now;
		logic [15:0] len;
		logic [15:0] ident;
		logic [15:0] flags;
		bit sum_ok;
		bit mf;
		hdr_words_t w;
		kind = $urandom_range(99);
		if (kind >= 95) begin
			foreach (w[i]) w[i] = 16'($urandom);
			push_header(w, $urandom);
			return;
		end
		dest = ($urandom_range(9) == 0) ? BROADCAST_ADDR : cfg_local_addr;
		case ($urandom_range(9))
			0:       len = 16'($urandom_range(59));
			1:       len = 16'($urandom_range(65535, 30000));
			default: len = 16'($urandom_range(1500, 60));
		endcase
		mf = $urandom_range(2) != 0;
		flags = (16'($urandom) & ~MORE_FRAGMENTS) | (mf ? MORE_FRAGMENTS : 16'h0000);
		ident = gen_ident;
		sum_ok = 1'b1;
		gap = (cfg_gap_limit == 8'd0) ? 32'd0 : 32'($urandom_range(cfg_gap_limit - 1));
		if (kind < 10)
			dest = $urandom;
		else if (kind < 18)
			sum_ok = 1'b0;
		else if (kind < 22)
			gap = 32'($urandom_range(cfg_gap_limit + 1000, cfg_gap_limit));
		else if (kind < 25)
			gap = 32'd0 - 32'($urandom_range(1000, 1));
		else if (kind < 30)
			ident = 16'($urandom);
		now = gen_prev + gap;
		if ((dest == cfg_local_addr || dest == BROADCAST_ADDR) && sum_ok) begin
			gen_prev = now;
			if (gap < cfg_gap_limit && (ident != gen_ident || !mf))
				gen_ident++;
		end
		send_packet(dest, len, ident, flags, 8'($urandom), sum_ok, now);
	endtask

	task automatic apb_write(logic reg_sel, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata != value)
			report_mismatch($sformatf("register %0d reads %h, want %h", reg_sel, prdata, value));
		psel <= 1'b0;
		penable <= 1'b0;
		if (reg_sel == REG_LOCAL_ADDRESS)
			cfg_local_addr = value;
		else
			cfg_gap_limit = value[7:0];
	endtask

	task automatic wait_quiet();
		while (items_accepted != items_queued || verdict_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(logic [31:0] local_addr, logic [7:0] limit, int packets,
			bit hold);
		wait_quiet();
		apb_write(REG_LOCAL_ADDRESS, local_addr);
		apb_write(REG_GAP_TIMEOUT, {24'd0, limit});
		gen_ident = ident_next;
		gen_prev = prev_arrival;
		repeat (packets) random_packet();
		if (hold)
			rx_hold_requests++;
	endtask

	initial begin
		hdr_words_t w;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle_pct = 6;
		rx_idle_pct = 66;

		// All-zero header: its sum folds to zero and it matches the reset address.
		foreach (w[i]) w[i] = 16'h0000;
		push_header(w, 32'd0);
		// All-ones header: broadcast, sum of all ones, identification mismatch.
		foreach (w[i]) w[i] = 16'hFFFF;
		push_header(w, 32'd5);
		send_packet(32'h0A00_0001, 16'd100, 16'd2, 16'h0000, 8'd6, 1'b1, 32'd6);
		send_packet(32'd0, 16'd100, 16'd2, 16'h0000, 8'd17, 1'b0, 32'd6);
		// A gap one below the limit still passes; the fragment opens a datagram.
		send_packet(32'd0, 16'd100, 16'd2, MORE_FRAGMENTS, 8'd17, 1'b1, 32'd34);
		send_packet(BROADCAST_ADDR, 16'd61, 16'd2, 16'h4000, 8'd17, 1'b1, 32'd40);
		send_packet(32'd0, 16'd80, 16'd3, 16'h0000, 8'd1, 1'b1, 32'd70);
		// Time going backwards wraps to a huge gap.
		send_packet(32'd0, 16'd80, 16'd3, 16'h0000, 8'd1, 1'b1, 32'd69);
		send_packet(32'd0, 16'd20, 16'd3, 16'h0000, 8'd255, 1'b1, 32'd70);

		run_phase($urandom, 8'd30, 5, 1'b0);
		run_phase(32'hFFFF_FFFF, 8'd255, 5, 1'b0);
		tx_idle_pct = 66;
		rx_idle_pct = 6;
		run_phase($urandom, 8'd1, 5, 1'b0);
		run_phase(32'd0, 8'd0, 3, 1'b0);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase($urandom, 8'd200, 5, 1'b1);
		run_phase($urandom, 8'($urandom_range(255, 2)), 3, 1'b0);
		wait_quiet();
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_word(s_tdata);
				items_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (word_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					s_tdata <= word_q.pop_front();
					s_tvalid <= 1'b1;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else begin
			if (m_tvalid && m_tready)
				check_verdict(m_tdata);
			m_tready <= rx_hold_left == 0 && $urandom_range(99) >= rx_idle_pct;
		end
	end

	// A long receiver hold-off lets the block fill up and stall its input.
	always @(posedge clk) begin
		if (rx_hold_served != rx_hold_requests) begin
			rx_hold_served <= rx_hold_requests;
			rx_hold_left <= RX_HOLD_CYCLES;
		end else if (rx_hold_left != 0)
			rx_hold_left <= rx_hold_left - 1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule
